// ===== hdl/uart_response_line_mode_tracker_core_assert.svh =====
// Assertion macros shared by the checker of the line and mode tracker.
`ifndef UART_RESPONSE_LINE_MODE_TRACKER_CORE_ASSERT_SVH
`define UART_RESPONSE_LINE_MODE_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define URLMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define URLMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/urlmt_pkg.sv =====
// Package: types, character codes and keyword tables of the line and mode tracker.
`timescale 1ns / 1ps
package urlmt_pkg;

  // Character codes
  localparam logic [7:0] LF_CHAR   = 8'h0A;
  localparam logic [7:0] CR_CHAR   = 8'h0D;
  localparam logic [7:0] HASH_CHAR = 8'h23;

  // Keyword matchers
  localparam int KW_COUNT  = 4;
  localparam int KW_MAXLEN = 19;
  localparam int KW_PW     = 5;
  localparam int KW_IW     = 2;

  localparam logic [KW_IW-1:0] KW_SPP_CLOSED = 2'd0;
  localparam logic [KW_IW-1:0] KW_CONN_DOWN  = 2'd1;
  localparam logic [KW_IW-1:0] KW_CMD_MODE   = 2'd2;
  localparam logic [KW_IW-1:0] KW_BYPASS     = 2'd3;

  // Keyword text, left-justified, zero padded to the longest keyword
  localparam logic [KW_MAXLEN*8-1:0] KW_TXT_SPP    = "SPPConnectionClosed";
  localparam logic [KW_MAXLEN*8-1:0] KW_TXT_DOWN   = {"ConnectionDown", 40'h0};
  localparam logic [KW_MAXLEN*8-1:0] KW_TXT_CMD    = {"CommandMode", 64'h0};
  localparam logic [KW_MAXLEN*8-1:0] KW_TXT_BYPASS = {"BypassMode", 72'h0};

  // Keyword length
  function automatic logic [KW_PW-1:0] kw_len(input logic [KW_IW-1:0] k);
    logic [KW_PW-1:0] len;
    unique case (k)
      KW_SPP_CLOSED: len = 5'd19;
      KW_CONN_DOWN:  len = 5'd14;
      KW_CMD_MODE:   len = 5'd11;
      KW_BYPASS:     len = 5'd10;
      default:       len = 5'd10;
    endcase
    return len;
  endfunction

  // Character at position p of keyword k; zero past the text
  function automatic logic [7:0] kw_char(input logic [KW_IW-1:0] k,
                                         input logic [KW_PW-1:0] p);
    logic [KW_MAXLEN*8-1:0] txt;
    logic [7:0]             ch;
    unique case (k)
      KW_SPP_CLOSED: txt = KW_TXT_SPP;
      KW_CONN_DOWN:  txt = KW_TXT_DOWN;
      KW_CMD_MODE:   txt = KW_TXT_CMD;
      KW_BYPASS:     txt = KW_TXT_BYPASS;
      default:       txt = KW_TXT_BYPASS;
    endcase
    if (int'(p) < KW_MAXLEN) begin
      ch = txt[8*(KW_MAXLEN-1-int'(p)) +: 8];
    end else begin
      ch = 8'h00;
    end
    return ch;
  endfunction

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_STATUS,
    ST_FWD,
    ST_CR,
    ST_LF
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic load_stat;
    logic load_byte;
    logic load_cr;
    logic load_lf;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fwd;
    logic keep_zero;
    logic last_byte;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/uart_response_line_mode_tracker_core.sv =====
// Top level: UART response line tracker with command/bypass mode and hash forwarding.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------------------
//   in      | in_valid, in_stall  | in_rx_byte
//   out     | out_valid, out_stall| out_bypass_active, out_cli_valid, out_cli_byte, out_last
//
// One byte at a time. A byte with a single status result passes the decide and status
// states from accept to the next accept, its result loaded in the status state; a hash
// forward of N stored bytes passes decide, forward, CR and LF, one forwarded byte per
// cycle while the output is not stalled, off the line store's registered read port, with
// the final LF loaded in the LF state. The next byte is taken once the previous byte's
// final result is loaded.
// rst_n is synchronous; it clears mode, fill count and matchers, not the store.
// A stalled result holds the result register and pauses the sequence.
`timescale 1ns / 1ps
module uart_response_line_mode_tracker_core #(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_bypass_active,
  output logic       out_cli_valid,
  output logic [7:0] out_cli_byte,
  output logic       out_last
);
  import urlmt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  urlmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Line store, matchers and result register
  urlmt_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_bypass_active (out_bypass_active),
    .out_cli_valid     (out_cli_valid),
    .out_cli_byte      (out_cli_byte),
    .out_last          (out_last)
  );

endmodule

// ===== hdl/urlmt_ctrl.sv =====
// Controller: sequences one received byte through decode, status or forward run.
`timescale 1ns / 1ps
module urlmt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output urlmt_pkg::cmd_t  cmd,
  input  urlmt_pkg::stat_t stat
);
  import urlmt_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!stat.fwd) begin
          state_nxt = ST_STATUS;
        end else if (stat.keep_zero) begin
          state_nxt = ST_CR;
        end else begin
          state_nxt = ST_FWD;
        end
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          cmd.load_stat = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FWD: begin
        if (stat.out_free) begin
          cmd.load_byte = 1'b1;
          if (stat.last_byte) begin
            state_nxt = ST_CR;
          end
        end
      end
      ST_CR: begin
        if (stat.out_free) begin
          cmd.load_cr = 1'b1;
          state_nxt   = ST_LF;
        end
      end
      ST_LF: begin
        if (stat.out_free) begin
          cmd.load_lf = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/urlmt_dp.sv =====
// Datapath: line store, fill count, keyword matchers, mode and result register.
`timescale 1ns / 1ps
module urlmt_dp #(
  parameter int LINE_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       in_rx_byte,
  input  urlmt_pkg::cmd_t  cmd,
  output urlmt_pkg::stat_t stat,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_bypass_active,
  output logic             out_cli_valid,
  output logic [7:0]       out_cli_byte,
  output logic             out_last
);
  import urlmt_pkg::*;

  localparam int AW    = $clog2(LINE_DEPTH);
  localparam int CNT_W = $clog2(LINE_DEPTH + 1);

  logic [7:0]          mem [LINE_DEPTH];
  logic [7:0]          rd_data_r;
  logic [CNT_W-1:0]    fill_r;
  logic [CNT_W-1:0]    cnt;
  logic [KW_PW-1:0]    prog_r   [KW_COUNT];
  logic [KW_PW-1:0]    prog_upd [KW_COUNT];
  logic [KW_COUNT-1:0] seen_r;
  logic [KW_COUNT-1:0] seen_upd;
  logic                prev_cr_r;
  logic                mode_r;
  logic                mode_nxt;
  logic                fwd_r;
  logic [AW-1:0]       keep_r;
  logic [AW-1:0]       idx_r;
  logic [AW-1:0]       idx_nxt;
  logic                line_end;
  logic                hash_fwd;
  logic                clear_line;
  logic                out_valid_r;
  logic                bypass_r;
  logic                cli_valid_r;
  logic [7:0]          cli_byte_r;
  logic                last_r;
  logic                load_any;

  // Incremental keyword match, one step per matcher
  always_comb begin
    seen_upd = seen_r;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (in_rx_byte == kw_char(KW_IW'(k), prog_r[k])) begin
        prog_upd[k] = prog_r[k] + KW_PW'(1);
      end else if (in_rx_byte == kw_char(KW_IW'(k), KW_PW'(0))) begin
        prog_upd[k] = KW_PW'(1);
      end else begin
        prog_upd[k] = '0;
      end
      if (prog_upd[k] == kw_len(KW_IW'(k))) begin
        seen_upd[k] = 1'b1;
        prog_upd[k] = '0;
      end
    end
  end

  // Line end, forward request and mode update
  always_comb begin
    cnt        = fill_r + CNT_W'(1);
    line_end   = (cnt > CNT_W'(2)) && (in_rx_byte == LF_CHAR) && prev_cr_r;
    hash_fwd   = !line_end && mode_r && (in_rx_byte == HASH_CHAR);
    clear_line = line_end || hash_fwd || (cnt >= CNT_W'(LINE_DEPTH));
    mode_nxt   = mode_r;
    if (line_end) begin
      if (mode_r) begin
        mode_nxt = !(seen_upd[KW_SPP_CLOSED] || seen_upd[KW_CONN_DOWN] ||
                     seen_upd[KW_CMD_MODE]);
      end else begin
        mode_nxt = seen_upd[KW_BYPASS];
      end
    end
  end

  // Line state, updated once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      seen_r    <= '0;
      prev_cr_r <= 1'b0;
      mode_r    <= 1'b0;
      fwd_r     <= 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
        prog_r[k] <= '0;
      end
    end else if (cmd.take) begin
      mode_r <= mode_nxt;
      fwd_r  <= hash_fwd;
      if (clear_line) begin
        fill_r    <= '0;
        seen_r    <= '0;
        prev_cr_r <= 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
          prog_r[k] <= '0;
        end
      end else begin
        fill_r    <= cnt;
        seen_r    <= seen_upd;
        prev_cr_r <= (in_rx_byte == CR_CHAR);
        for (int k = 0; k < KW_COUNT; k++) begin
          prog_r[k] <= prog_upd[k];
        end
      end
    end
  end

  // Bytes ahead of the hash; fill is below depth here
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      keep_r <= fill_r[AW-1:0];
    end
  end

  // Forward index; the read address runs one step ahead
  always_comb begin
    if (cmd.take) begin
      idx_nxt = '0;
    end else if (cmd.load_byte) begin
      idx_nxt = idx_r + AW'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // Line store: write on accept, registered read
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[fill_r[AW-1:0]] <= in_rx_byte;
    end
    rd_data_r <= mem[idx_nxt];
  end

  // Result register
  assign load_any = cmd.load_stat || cmd.load_byte || cmd.load_cr || cmd.load_lf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_any) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_any) begin
      bypass_r    <= mode_r;
      cli_valid_r <= !cmd.load_stat;
      last_r      <= cmd.load_stat || cmd.load_lf;
      priority if (cmd.load_byte) begin
        cli_byte_r <= rd_data_r;
      end else if (cmd.load_cr) begin
        cli_byte_r <= CR_CHAR;
      end else if (cmd.load_lf) begin
        cli_byte_r <= LF_CHAR;
      end else begin
        cli_byte_r <= 8'h00;
      end
    end
  end

  // Status to the controller
  always_comb begin
    stat.fwd       = fwd_r;
    stat.keep_zero = (keep_r == '0);
    stat.last_byte = ({1'b0, idx_r} + (AW+1)'(1)) == {1'b0, keep_r};
    stat.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_bypass_active = bypass_r;
  assign out_cli_valid     = cli_valid_r;
  assign out_cli_byte      = cli_byte_r;
  assign out_last          = last_r;

endmodule

// ===== hdl/urlmt_checker.sv =====
// Port-level checker for the line and mode tracker, bound to the top level.
`timescale 1ns / 1ps
`include "uart_response_line_mode_tracker_core_assert.svh"
module urlmt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_bypass_active,
  input logic       out_cli_valid,
  input logic [7:0] out_cli_byte,
  input logic       out_last
);
  import urlmt_pkg::*;

  // A held result keeps its payload
  `URLMT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bypass_active) && $stable(out_cli_valid) && $stable(out_cli_byte) && $stable(out_last), "result changed while stalled")

  // Bytes are taken one at a time: never two accepts back to back
  `URLMT_ASSERT_NEXT(a_in_gap, in_valid && !in_stall, in_stall, "byte accepted in the cycle after an accept")

  // A status result carries no byte and closes its item
  `URLMT_ASSERT_NOW(a_status, out_valid && !out_cli_valid, out_last && (out_cli_byte == 8'h00), "malformed status result")

  // A forward run always ends on LF
  `URLMT_ASSERT_NOW(a_fwd_end, out_valid && out_cli_valid && out_last, out_cli_byte == LF_CHAR, "forward run not closed by LF")

endmodule

bind uart_response_line_mode_tracker_core urlmt_checker u_urlmt_checker (.*);
